### rtl/core/msst_pkg.sv
// Shared constants for the minimum-slimness spanning tree unit.
package msst_pkg;

	// Default sizes of the vertex set, the edge store and the weights.
	localparam int DEF_MAX_VERTICES = 128;
	localparam int DEF_MAX_EDGES    = 4096;
	localparam int DEF_WEIGHT_BITS  = 16;

	// Register index of the vertex count on the configuration port.
	localparam logic REG_VERTEX_COUNT = 1'b0;

	// Widths of the stream payloads.
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 2;

endpackage

### rtl/core/msst_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module msst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/min_slimness_spanning_tree_unit.sv
// Top level of the minimum-slimness spanning tree unit: loader, sorter and Kruskal sequencer.
//
//  Channel  | Direction | Word contents
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | one edge; tlast marks the last edge of a graph
//  m_*      | out       | one result per graph: slim value and two flags
//  APB      | in/out    | register 0: vertex_count
//
// An edge word is placed by insertion: each stored edge with a larger key is read and
// moved up one place before the new key is written, since edges are kept sorted
// through the single edge RAM port pair.
// After the last edge, Kruskal passes run from successive start positions until the
// first pass finds no spanning tree or too few edges remain: each pass resets the set
// RAM, then for each edge reads it, finds both roots by following parent links and
// joins them, raising the rank of the new root when the ranks are equal.
// Reset is asynchronous and clears control state only; s_tready is low while an edge
// is inserted and, after the last edge, until its result is taken.
module min_slimness_spanning_tree_unit #(
	parameter int MAX_VERTICES = msst_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = msst_pkg::DEF_MAX_EDGES,
	parameter int WEIGHT_BITS  = msst_pkg::DEF_WEIGHT_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// first_vertex [7:0], second_vertex [15:8], edge_weight [31:16]
	input  logic [msst_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// slim_value [15:0]
	output logic [msst_pkg::OUT_DATA_W-1:0] m_tdata,
	// spanning_found [0], edges_overflowed [1]
	output logic [msst_pkg::OUT_USER_W-1:0] m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	import msst_pkg::*;

	localparam int AW    = $clog2(MAX_EDGES);
	localparam int TW    = $clog2(MAX_EDGES + 1);
	localparam int VW    = $clog2(MAX_VERTICES + 1);
	localparam int RW    = $clog2(VW + 1);
	localparam int EW    = RW + VW;
	localparam int KEY_W = WEIGHT_BITS + 16;
	localparam int SDEPTH = MAX_VERTICES + 1;
	localparam int SAW   = $clog2(SDEPTH);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_INS   = 4'd1;
	localparam logic [3:0] ST_INSC  = 4'd2;
	localparam logic [3:0] ST_START = 4'd3;
	localparam logic [3:0] ST_INIT  = 4'd4;
	localparam logic [3:0] ST_ERD   = 4'd5;
	localparam logic [3:0] ST_EWAIT = 4'd6;
	localparam logic [3:0] ST_FRD   = 4'd7;
	localparam logic [3:0] ST_FCMP  = 4'd8;
	localparam logic [3:0] ST_JOIN  = 4'd9;
	localparam logic [3:0] ST_JOIN2 = 4'd10;
	localparam logic [3:0] ST_RUND  = 4'd11;
	localparam logic [3:0] ST_OUT   = 4'd12;

	logic [3:0]             state_q;
	logic [7:0]             vc_q;
	logic [TW-1:0]          total_q;
	logic                   ovf_q;
	logic                   last_q;
	logic [KEY_W-1:0]       key_q;
	logic [AW-1:0]          j_q;
	logic [TW-1:0]          s_q;
	logic [TW-1:0]          i_q;
	logic [VW-1:0]          ix_q;
	logic [VW-1:0]          cnt_q;
	logic [VW-1:0]          x_q;
	logic                   phase_q;
	logic [VW-1:0]          a_q;
	logic [VW-1:0]          b_q;
	logic [RW-1:0]          ra_q;
	logic [RW-1:0]          rb_q;
	logic [WEIGHT_BITS-1:0] mx_q;
	logic [WEIGHT_BITS-1:0] ws_q;
	logic [WEIGHT_BITS-1:0] best_q;
	logic                   found_q;

	// Effective vertex count.
	logic [8:0]    vc_ext;
	logic [VW-1:0] nv;
	logic [VW-1:0] nv_m1;
	always_comb begin
		vc_ext = {1'b0, vc_q};
		if (vc_q == 8'd0) begin
			nv = VW'(1);
		end else if (32'(vc_ext) > MAX_VERTICES) begin
			nv = VW'(MAX_VERTICES);
		end else begin
			nv = vc_q[VW-1:0] & {VW{1'b1}};
		end
		nv_m1 = nv - VW'(1);
	end

	// Incoming edge fields.
	logic [7:0]             in_u;
	logic [7:0]             in_v;
	logic [31:0]            in_w32;
	logic [WEIGHT_BITS-1:0] in_w;
	logic                   in_ok;
	assign in_u   = s_tdata[7:0];
	assign in_v   = s_tdata[15:8];
	assign in_w32 = {16'b0, s_tdata[31:16]};
	assign in_w   = in_w32[WEIGHT_BITS-1:0];
	assign in_ok  = (in_u != 8'd0) && (32'(in_u) <= 32'(nv))
		&& (in_v != 8'd0) && (32'(in_v) <= 32'(nv));

	// Edge RAM holding sort keys {weight, first, second}.
	logic             e_we;
	logic [AW-1:0]    e_waddr;
	logic [KEY_W-1:0] e_wdata;
	logic [AW-1:0]    e_raddr;
	logic [KEY_W-1:0] e_rdata;

	msst_ram #(.WIDTH(KEY_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	// Set RAM holding {rank, parent} for each vertex.
	logic           p_we;
	logic [SAW-1:0] p_waddr;
	logic [EW-1:0]  p_wdata;
	logic [SAW-1:0] p_raddr;
	logic [EW-1:0]  p_rdata;

	msst_ram #(.WIDTH(EW), .DEPTH(SDEPTH)) u_set_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	// Fields of the current edge and of the set entry just read.
	logic [VW-1:0]          cur_v;
	logic [WEIGHT_BITS-1:0] cur_w;
	logic [VW-1:0]          ent_par;
	logic [RW-1:0]          ent_rank;
	logic [WEIGHT_BITS-1:0] diff;
	logic                   spans;
	logic [TW-1:0]          s_next;
	logic [TW-1:0]          remain;
	assign cur_v    = key_q[0 +: VW];
	assign cur_w    = key_q[KEY_W-1:16];
	assign ent_par  = p_rdata[VW-1:0];
	assign ent_rank = p_rdata[EW-1:VW];
	assign diff     = mx_q - ws_q;
	assign spans    = (cnt_q == nv_m1);
	assign s_next   = s_q + TW'(1);
	assign remain   = total_q - s_next;

	// RAM port control.
	always_comb begin
		e_we    = 1'b0;
		e_waddr = j_q;
		e_wdata = key_q;
		e_raddr = i_q[AW-1:0];
		p_we    = 1'b0;
		p_waddr = SAW'(ix_q);
		p_wdata = {RW'(0), ix_q};
		p_raddr = SAW'(x_q);
		unique case (state_q)
			ST_INS: begin
				e_raddr = j_q - AW'(1);
				if (j_q == AW'(0)) begin
					e_we = 1'b1;
				end
			end
			ST_INSC: begin
				e_we = 1'b1;
				if (e_rdata > key_q) begin
					e_wdata = e_rdata;
				end
			end
			ST_INIT: begin
				p_we = 1'b1;
			end
			ST_JOIN: begin
				if (a_q != b_q) begin
					p_we = 1'b1;
					if (ra_q > rb_q) begin
						p_waddr = SAW'(b_q);
						p_wdata = {rb_q, a_q};
					end else begin
						p_waddr = SAW'(a_q);
						p_wdata = {ra_q, b_q};
					end
				end
			end
			ST_JOIN2: begin
				p_we    = 1'b1;
				p_waddr = SAW'(b_q);
				p_wdata = {rb_q + RW'(1), b_q};
			end
			default: begin
			end
		endcase
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (in_ok && (32'(total_q) < MAX_EDGES)) begin
							state_q <= ST_INS;
						end else begin
							if (in_ok) begin
								ovf_q <= 1'b1;
							end
							state_q <= s_tlast ? ST_START : ST_IDLE;
						end
					end
				end
				ST_INS: begin
					if (j_q == AW'(0)) begin
						total_q <= total_q + TW'(1);
						state_q <= last_q ? ST_START : ST_IDLE;
					end else begin
						state_q <= ST_INSC;
					end
				end
				ST_INSC: begin
					if (e_rdata > key_q) begin
						state_q <= ST_INS;
					end else begin
						total_q <= total_q + TW'(1);
						state_q <= last_q ? ST_START : ST_IDLE;
					end
				end
				ST_START: begin
					if (nv == VW'(1) || total_q == TW'(0)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (ix_q == nv) begin
						state_q <= ST_ERD;
					end
				end
				ST_ERD: begin
					if (i_q < total_q && cnt_q < nv_m1) begin
						state_q <= ST_EWAIT;
					end else begin
						state_q <= ST_RUND;
					end
				end
				ST_EWAIT: state_q <= ST_FRD;
				ST_FRD:   state_q <= ST_FCMP;
				ST_FCMP: begin
					if (ent_par == x_q && phase_q) begin
						state_q <= ST_JOIN;
					end else begin
						state_q <= ST_FRD;
					end
				end
				ST_JOIN: begin
					if (a_q != b_q && ra_q == rb_q) begin
						state_q <= ST_JOIN2;
					end else begin
						state_q <= ST_ERD;
					end
				end
				ST_JOIN2: state_q <= ST_ERD;
				ST_RUND: begin
					if (s_q == TW'(0) && !spans) begin
						state_q <= ST_OUT;
					end else if (s_next < total_q && 32'(remain) >= 32'(nv_m1)) begin
						state_q <= ST_INIT;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						total_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				key_q  <= {in_w, in_u, in_v};
				j_q    <= total_q[AW-1:0];
				last_q <= s_tlast;
			end
			ST_INSC: begin
				if (e_rdata > key_q) begin
					j_q <= j_q - AW'(1);
				end
			end
			ST_START: begin
				found_q <= (nv == VW'(1));
				best_q  <= '0;
				s_q     <= '0;
				ix_q    <= '0;
			end
			ST_INIT: begin
				ix_q  <= ix_q + VW'(1);
				i_q   <= s_q;
				cnt_q <= '0;
				mx_q  <= '0;
			end
			ST_EWAIT: begin
				key_q   <= e_rdata;
				x_q     <= e_rdata[8 +: VW];
				phase_q <= 1'b0;
				if (i_q == s_q) begin
					ws_q <= e_rdata[KEY_W-1:16];
				end
			end
			ST_FCMP: begin
				if (ent_par == x_q) begin
					if (!phase_q) begin
						a_q     <= x_q;
						ra_q    <= ent_rank;
						x_q     <= cur_v;
						phase_q <= 1'b1;
					end else begin
						b_q  <= x_q;
						rb_q <= ent_rank;
					end
				end else begin
					x_q <= ent_par;
				end
			end
			ST_JOIN: begin
				if (a_q != b_q) begin
					mx_q  <= cur_w;
					cnt_q <= cnt_q + VW'(1);
				end
				if (!(a_q != b_q && ra_q == rb_q)) begin
					i_q <= i_q + TW'(1);
				end
			end
			ST_JOIN2: i_q <= i_q + TW'(1);
			ST_RUND: begin
				if (s_q == TW'(0)) begin
					found_q <= spans;
					best_q  <= spans ? diff : '0;
				end else if (spans && diff < best_q) begin
					best_q <= diff;
				end
				s_q  <= s_next;
				ix_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// Stream outputs.
	logic [31:0] best_ext;
	assign best_ext = 32'(best_q);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = best_ext[15:0];
	assign m_tuser  = {ovf_q, found_q};

	// Configuration port.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= 8'd1;
		end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
			vc_q <= pwdata[7:0];
		end
	end
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {24'b0, vc_q} : 32'b0;

endmodule

### bench/tb_min_slimness_spanning_tree_unit.sv
// Self-checking testbench for the minimum-slimness spanning tree unit.
`timescale 1ns / 100ps

module tb_min_slimness_spanning_tree_unit;
	import msst_pkg::*;

	localparam int N_VERT    = DEF_MAX_VERTICES;
	localparam int N_EDGES   = DEF_MAX_EDGES;
	localparam int IDLE_MAX  = 300000;

	typedef struct packed {
		logic [7:0]  first_vertex;
		logic [7:0]  second_vertex;
		logic [15:0] edge_weight;
		logic        last_edge;
	} edge_word_t;

	typedef struct packed {
		logic [15:0] slim_value;
		logic        spanning_found;
		logic        edges_overflowed;
	} slim_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	edge_word_t   edge_q[$];
	slim_result_t slim_q[$];
	logic [31:0]  graph_keys[$];
	edge_word_t   cur_edge;
	logic [7:0]   vcount_reg = 8'd1;
	logic         ovf_seen = 1'b0;
	logic [7:0]   set_par[0:N_VERT];
	bit           edge_taken = 1'b0;
	bit           quiet = 1'b0;
	int           errors = 0;
	int           results_seen = 0;
	int           idle_cycles = 0;
	int           s_gap = 0;
	int           r_gap = 0;
	int           hold_left = 0;
	int           items_sent = 0;

	min_slimness_spanning_tree_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Effective vertex count: zero acts as one, large values clamp.
	function automatic int eff_vertices();
		int v;
		v = int'(vcount_reg);
		if (v == 0) v = 1;
		if (v > N_VERT) v = N_VERT;
		return v;
	endfunction

	function automatic int set_root(int x);
		while (int'(set_par[x]) != x) x = int'(set_par[x]);
		return x;
	endfunction

	// One Kruskal pass over the sorted keys from position start.
	function automatic bit tree_from(int start, int nv, output int mx);
		int cnt;
		int a;
		int b;
		mx = 0;
		cnt = 0;
		for (int i = 0; i <= nv; i++) set_par[i] = 8'(i);
		for (int i = start; i < graph_keys.size() && cnt < nv - 1; i++) begin
			a = set_root(int'(graph_keys[i][15:8]));
			b = set_root(int'(graph_keys[i][7:0]));
			if (a != b) begin
				set_par[a] = 8'(b);
				mx = int'(graph_keys[i][31:16]);
				cnt++;
			end
		end
		return cnt == nv - 1;
	endfunction

	// Slimness of the graph collected so far; clears the collection.
	function automatic slim_result_t graph_slimness(int nv);
		slim_result_t r;
		int mx;
		int n;
		int d;
		r = '0;
		n = graph_keys.size();
		if (nv == 1) begin
			r.spanning_found = 1'b1;
		end else if (n > 0) begin
			graph_keys.sort();
			if (tree_from(0, nv, mx)) begin
				r.spanning_found = 1'b1;
				d = mx - int'(graph_keys[0][31:16]);
				for (int i = 1; i < n && n - i >= nv - 1; i++) begin
					if (tree_from(i, nv, mx) && mx - int'(graph_keys[i][31:16]) < d)
						d = mx - int'(graph_keys[i][31:16]);
				end
				r.slim_value = 16'(d);
			end
		end
		r.edges_overflowed = ovf_seen;
		graph_keys.delete();
		ovf_seen = 1'b0;
		return r;
	endfunction

	// Accepted edge words update the predicted store.
	always @(posedge clk) begin
		int nv;
		nv = eff_vertices();
		if (s_tvalid && s_tready) begin
			edge_taken = 1'b1;
			idle_cycles = 0;
			if (cur_edge.first_vertex >= 1 && cur_edge.first_vertex <= nv &&
			    cur_edge.second_vertex >= 1 && cur_edge.second_vertex <= nv) begin
				if (graph_keys.size() < N_EDGES)
					graph_keys.insert(graph_keys.size(), {cur_edge.edge_weight,
						cur_edge.first_vertex, cur_edge.second_vertex});
				else
					ovf_seen = 1'b1;
			end
			if (cur_edge.last_edge) slim_q.insert(slim_q.size(), graph_slimness(nv));
		end
	end

	// Result words are compared with the oldest prediction.
	always @(posedge clk) begin
		slim_result_t want;
		if (m_tvalid && m_tready) begin
			idle_cycles = 0;
			results_seen++;
			if (results_seen == 4) hold_left = 500;
			if (slim_q.size() == 0) begin
				$display("%0t: unexpected result word slim=%0d user=%b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = slim_q.pop_front();
				if (m_tdata !== want.slim_value || m_tuser[0] !== want.spanning_found ||
				    m_tuser[1] !== want.edges_overflowed) begin
					$display("%0t: mismatch expected slim=%0d found=%b ovf=%b, got slim=%0d found=%b ovf=%b",
						$time, want.slim_value, want.spanning_found, want.edges_overflowed,
						m_tdata, m_tuser[0], m_tuser[1]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if (arst_n) idle_cycles++;
		if (idle_cycles >= IDLE_MAX) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Edge driver with random gaps.
	always @(negedge clk) begin
		bit send;
		send = 1'b0;
		if (!s_tvalid || edge_taken) begin
			edge_taken = 1'b0;
			if (!quiet && s_gap == 0 && $urandom_range(0, 7) == 0) s_gap = $urandom_range(1, 5);
			if (s_gap > 0) begin
				s_gap--;
			end else if (edge_q.size() > 0) begin
				cur_edge = edge_q.pop_front();
				items_sent++;
				send = 1'b1;
			end
			s_tvalid <= send;
			if (send) begin
				s_tdata <= {cur_edge.edge_weight, cur_edge.second_vertex, cur_edge.first_vertex};
				s_tlast <= cur_edge.last_edge;
			end
		end
	end

	// Result receiver with random stalls and one long hold.
	always @(negedge clk) begin
		bit rdy;
		rdy = 1'b1;
		if (!arst_n) begin
			rdy = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else begin
			if (!quiet && r_gap == 0 && $urandom_range(0, 5) == 0) r_gap = $urandom_range(1, 5);
			if (r_gap > 0) begin
				r_gap--;
				rdy = 1'b0;
			end
		end
		m_tready <= rdy;
	end

	task automatic reg_write(input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(REG_VERTEX_COUNT) * 3'd4;
		pwdata <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		vcount_reg = value;
	endtask

	task automatic push_edge(input int a, input int b, input int w, input bit last);
		edge_word_t e;
		e.first_vertex = 8'(a);
		e.second_vertex = 8'(b);
		e.edge_weight = 16'(w);
		e.last_edge = last;
		edge_q.insert(edge_q.size(), e);
	endtask

	// Wait until the block has delivered every predicted result.
	task automatic drain();
		while (edge_q.size() > 0 || s_tvalid || slim_q.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Random graph: mostly a random spanning tree plus extra edges, some noise.
	task automatic random_graph(input int nv, input int extra, input int wmax, input bit broken);
		int a;
		int perm[$];
		int sel;
		edge_word_t pend[$];
		edge_word_t e;
		for (int i = 1; i <= nv; i++) perm.insert(perm.size(), i);
		perm.shuffle();
		for (int i = 1; i < nv; i++) begin
			if (broken && $urandom_range(0, 3) == 0) continue;
			e.first_vertex = 8'(perm[i]);
			e.second_vertex = 8'(perm[$urandom_range(0, i - 1)]);
			if ($urandom_range(0, 1)) begin
				a = int'(e.first_vertex);
				e.first_vertex = e.second_vertex;
				e.second_vertex = 8'(a);
			end
			e.edge_weight = 16'($urandom_range(0, wmax));
			e.last_edge = 1'b0;
			pend.insert(pend.size(), e);
		end
		for (int i = 0; i < extra; i++) begin
			sel = $urandom_range(0, 9);
			e.first_vertex = 8'((sel == 0) ? $urandom_range(0, 255) : $urandom_range(1, nv));
			e.second_vertex = 8'((sel == 1) ? $urandom_range(0, 255) : $urandom_range(1, nv));
			e.edge_weight = 16'($urandom_range(0, wmax));
			e.last_edge = 1'b0;
			pend.insert(pend.size(), e);
		end
		if (pend.size() == 0) begin
			e.first_vertex = 8'd1;
			e.second_vertex = 8'd1;
			e.edge_weight = 16'($urandom_range(0, wmax));
			pend.insert(pend.size(), e);
		end
		pend.shuffle();
		pend[pend.size() - 1].last_edge = 1'b1;
		foreach (pend[i]) edge_q.insert(edge_q.size(), pend[i]);
	endtask

	initial begin
		int nv;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset value: single vertex, with a self loop and a dropped edge.
		push_edge(1, 1, 0, 1);
		push_edge(0, 0, 16'hFFFF, 1);
		drain();

		// Vertex count zero behaves as one.
		reg_write(8'd0);
		push_edge(2, 1, 7, 1);
		drain();

		// Two vertices: no stored edge, extreme weights, self loop.
		reg_write(8'd2);
		push_edge(3, 1, 5, 1);
		push_edge(1, 2, 16'hFFFF, 0);
		push_edge(2, 1, 0, 1);
		push_edge(1, 1, 5, 0);
		push_edge(2, 1, 16'hFFFF, 1);
		push_edge(1, 1, 9, 1);
		drain();

		// Four vertices: disconnected graph, then a graph with ties.
		reg_write(8'd4);
		push_edge(1, 2, 3, 0);
		push_edge(3, 4, 3, 1);
		push_edge(1, 2, 10, 0);
		push_edge(2, 3, 10, 0);
		push_edge(3, 4, 40, 0);
		push_edge(4, 1, 12, 0);
		push_edge(2, 4, 11, 0);
		push_edge(4, 4, 1, 0);
		push_edge(128, 5, 2, 1);
		drain();

		// Largest vertex counts, clamped and exact.
		reg_write(8'd255);
		random_graph(128, 4, 65535, 0);
		drain();
		reg_write(8'd128);
		random_graph(128, 2, 65535, 0);
		drain();

		// Random graphs over several vertex counts.
		while (items_sent < 800) begin
			nv = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(2, 8);
			reg_write(8'(nv));
			repeat ($urandom_range(2, 5)) begin
				if (items_sent > 700) quiet = 1'b1;
				random_graph(nv, $urandom_range(0, 2 * nv),
					($urandom_range(0, 1) ? 65535 : 15), $urandom_range(0, 4) == 0);
				if ($urandom_range(0, 3) == 0)
					while (edge_q.size() > 0 || slim_q.size() > 0) @(negedge clk);
				else
					while (edge_q.size() > 0) @(negedge clk);
			end
			drain();
		end

		drain();
		repeat (100) @(negedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
